>>> src/mtpo_pkg.sv
// Shared constants, widths and types of the multichannel tone phase offset unit.
package mtpo_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FRAME   = 8192;
  localparam int MAX_PERIOD  = 4096;

  // Derived widths.
  localparam int POS_W      = $clog2(MAX_FRAME);
  localparam int LEN_W      = $clog2(MAX_FRAME + 1);
  localparam int P_W        = $clog2(MAX_PERIOD + 1);
  localparam int IDX1_W     = $clog2(MAX_PERIOD);
  localparam int DIFF_W     = POS_W + 1;
  localparam int DIV_STAGES = POS_W;

  // Register and field widths fixed by the register map and the ports.
  localparam int SPP_W  = 13;
  localparam int FLEN_W = 14;
  localparam int UPD_W  = 16;
  localparam int ACT_W  = 3;
  localparam int CNT_W  = 17;
  localparam int OFF_W  = 13;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [1:0] REG_SPP  = 2'd0;
  localparam logic [1:0] REG_FLEN = 2'd1;
  localparam logic [1:0] REG_UPD  = 2'd2;
  localparam logic [1:0] REG_ACT  = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OFF_W-1:0]       offset_t;

  // Peak positions that a tracker lane reports for the sample just taken.
  typedef struct packed {
    logic [IDX1_W-1:0] first_idx;
    logic [POS_W-1:0]  second_idx;
  } peak_idx_t;

  // Control that travels alongside the remainder pipeline.
  typedef struct packed {
    logic             valid;
    logic             meas;
    logic [ACT_W-1:0] act;
  } pipe_ctl_t;

endpackage

>>> src/mtpo_peak_lane.sv
// Per-channel tracker of the first strict maximum in each of the first two tone periods.
module mtpo_peak_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  mtpo_pkg::sample_t         sample,
  input  logic [mtpo_pkg::POS_W-1:0] pos,
  input  logic [mtpo_pkg::P_W-1:0]   period,
  output mtpo_pkg::peak_idx_t       idx_nxt
);
  import mtpo_pkg::*;

  sample_t           first_val_r, first_val_nxt;
  sample_t           second_val_r, second_val_nxt;
  logic [IDX1_W-1:0] first_idx_r, first_idx_nxt;
  logic [POS_W-1:0]  second_idx_r, second_idx_nxt;
  logic              in_first, in_second;

  always_comb begin
    in_first  = (pos == '0) ||
                ((POS_W + 1)'(pos) < (POS_W + 1)'(period) && sample > first_val_r);
    in_second = ((POS_W + 1)'(pos) == (POS_W + 1)'(period)) ||
                ((POS_W + 1)'(pos) > (POS_W + 1)'(period) &&
                 (P_W + 1)'(pos) < {period, 1'b0} && sample > second_val_r);
    first_val_nxt  = first_val_r;
    first_idx_nxt  = first_idx_r;
    second_val_nxt = second_val_r;
    second_idx_nxt = second_idx_r;
    if (acc && in_first) begin
      first_val_nxt = sample;
      first_idx_nxt = pos[IDX1_W-1:0];
    end
    if (acc && in_second) begin
      second_val_nxt = sample;
      second_idx_nxt = pos;
    end
  end

  assign idx_nxt = '{first_idx: first_idx_nxt, second_idx: second_idx_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_val_r  <= '0;
      first_idx_r  <= '0;
      second_val_r <= '0;
      second_idx_r <= '0;
    end else begin
      first_val_r  <= first_val_nxt;
      first_idx_r  <= first_idx_nxt;
      second_val_r <= second_val_nxt;
      second_idx_r <= second_idx_nxt;
    end
  end

endmodule

>>> src/mtpo_rem_lane.sv
// Per-channel peak selection and pipelined truncated remainder by the tone period.
module mtpo_rem_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mtpo_pkg::IDX1_W-1:0] ref_idx,
  input  mtpo_pkg::peak_idx_t         idx,
  input  logic [mtpo_pkg::P_W-1:0]    period,
  output mtpo_pkg::offset_t           offset
);
  import mtpo_pkg::*;

  logic signed [DIFF_W-1:0] d1, d2;
  logic [DIFF_W-1:0]        a1, a2;
  logic                     neg_nxt;
  logic [POS_W-1:0]         mag_nxt;

  logic             neg_r [DIV_STAGES+1];
  logic [POS_W-1:0] dvd_r [DIV_STAGES+1];
  logic [P_W-1:0]   per_r [DIV_STAGES+1];
  logic [P_W-1:0]   rem_r [DIV_STAGES+1];
  logic [P_W-1:0]   rem_nxt [DIV_STAGES+1];
  offset_t          mag_off;

  // Choose the nearer peak; the first one wins only when strictly nearer.
  always_comb begin
    d1 = $signed(DIFF_W'(ref_idx)) - $signed(DIFF_W'(idx.first_idx));
    d2 = $signed(DIFF_W'(ref_idx)) - $signed(DIFF_W'(idx.second_idx));
    a1 = d1[DIFF_W-1] ? DIFF_W'(-d1) : DIFF_W'(d1);
    a2 = d2[DIFF_W-1] ? DIFF_W'(-d2) : DIFF_W'(d2);
    if (a1 < a2) begin
      neg_nxt = d1[DIFF_W-1];
      mag_nxt = a1[POS_W-1:0];
    end else begin
      neg_nxt = d2[DIFF_W-1];
      mag_nxt = a2[POS_W-1:0];
    end
  end

  assign rem_nxt[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= neg_nxt;
      dvd_r[0] <= mag_nxt;
      per_r[0] <= period;
      rem_r[0] <= rem_nxt[0];
    end
  end

  // One restoring step per stage, most significant dividend bit first.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [P_W:0] sh;
    always_comb begin
      sh = {rem_r[k], dvd_r[k][DIV_STAGES-1-k]};
      if (sh >= (P_W + 1)'(per_r[k])) begin
        rem_nxt[k+1] = P_W'(sh - (P_W + 1)'(per_r[k]));
      end else begin
        rem_nxt[k+1] = sh[P_W-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k+1] <= neg_r[k];
        dvd_r[k+1] <= dvd_r[k];
        per_r[k+1] <= per_r[k];
        rem_r[k+1] <= rem_nxt[k+1];
      end
    end
  end

  // The remainder takes the sign of the difference.
  assign mag_off = offset_t'(rem_r[DIV_STAGES]);
  assign offset  = neg_r[DIV_STAGES] ? offset_t'(-mag_off) : mag_off;

endmodule

>>> src/multichannel_tone_phase_offset_unit.sv
// Top level of the multichannel tone phase offset unit: control, lanes, merge and registers.
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid / in_stall  in_sample_ch0 .. in_sample_ch3
//   out       source     out_valid / out_stall out_offset_ch1 .. out_offset_ch3
//   cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata
//
// One sample transaction is taken every clock cycle while in_stall is low. A frame's
// result reaches the output register through one capture stage, one peak selection
// stage and a 13-stage restoring remainder pipeline per channel. Reset is synchronous
// and active low; it restores the register defaults and arms a measurement for the
// first frame. A result that waits in the output register stalls the input only once
// the pipeline's last stage also holds a result; bubbles in the pipeline keep moving.
module multichannel_tone_phase_offset_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtpo_pkg::ADDR_W-1:0]   paddr,
  input  logic [mtpo_pkg::DATA_W-1:0]   pwdata,
  output logic [mtpo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mtpo_pkg::sample_t             in_sample_ch0,
  input  mtpo_pkg::sample_t             in_sample_ch1,
  input  mtpo_pkg::sample_t             in_sample_ch2,
  input  mtpo_pkg::sample_t             in_sample_ch3,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mtpo_pkg::offset_t             out_offset_ch1,
  output mtpo_pkg::offset_t             out_offset_ch2,
  output mtpo_pkg::offset_t             out_offset_ch3
);
  import mtpo_pkg::*;

  // Configuration registers.
  logic [SPP_W-1:0]  spp_r;
  logic [FLEN_W-1:0] flen_r;
  logic [UPD_W-1:0]  upd_r;
  logic [ACT_W-1:0]  act_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r  <= SPP_W'(16);
      flen_r <= FLEN_W'(64);
      upd_r  <= '0;
      act_r  <= ACT_W'(4);
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_SPP:  spp_r  <= pwdata[SPP_W-1:0];
        REG_FLEN: flen_r <= pwdata[FLEN_W-1:0];
        REG_UPD:  upd_r  <= pwdata[UPD_W-1:0];
        REG_ACT:  act_r  <= pwdata[ACT_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_SPP:  prdata = DATA_W'(spp_r);
      REG_FLEN: prdata = DATA_W'(flen_r);
      REG_UPD:  prdata = DATA_W'(upd_r);
      REG_ACT:  prdata = DATA_W'(act_r);
      default:  prdata = '0;
    endcase
  end

  // Register values clamped into their working ranges. The period is held to
  // half the frame so that both tone periods always fit.
  logic [LEN_W-1:0] len_c;
  logic [P_W-1:0]   p_lim, p_c;
  logic [LEN_W-2:0] half_len;
  logic [ACT_W-1:0] act_c;

  always_comb begin
    if (int'(flen_r) < 4) begin
      len_c = LEN_W'(4);
    end else if (int'(flen_r) > MAX_FRAME) begin
      len_c = LEN_W'(MAX_FRAME);
    end else begin
      len_c = LEN_W'(flen_r);
    end
    half_len = len_c[LEN_W-1:1];
    p_lim = (int'(spp_r) > MAX_PERIOD) ? P_W'(MAX_PERIOD) : P_W'(spp_r);
    if (LEN_W'(p_lim) > LEN_W'(half_len)) begin
      p_lim = P_W'(half_len);
    end
    p_c = (p_lim < P_W'(2)) ? P_W'(2) : p_lim;
    if (act_r < ACT_W'(2)) begin
      act_c = ACT_W'(2);
    end else if (int'(act_r) > CHANNELS) begin
      act_c = ACT_W'(CHANNELS);
    end else begin
      act_c = act_r;
    end
  end

  // Pipeline advance. Everything moves together unless a finished result is
  // both in the pipeline's last stage and blocked in the output register.
  pipe_ctl_t ctl_r [DIV_STAGES+1];
  logic      out_valid_r;
  logic      en, acc;

  assign en       = !ctl_r[DIV_STAGES].valid || !out_valid_r || !out_stall;
  assign acc      = in_valid && en;
  assign in_stall = !en;

  // Frame position and refresh counter.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             pending_r, pending_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             frame_end, meas;

  always_comb begin
    frame_end   = (LEN_W'(pos_r) + LEN_W'(1)) >= len_c;
    pos_nxt     = pos_r;
    pending_nxt = pending_r;
    cnt_nxt     = cnt_r;
    meas        = 1'b0;
    if (acc) begin
      pos_nxt = frame_end ? '0 : POS_W'(pos_r + POS_W'(1));
      if (frame_end) begin
        if (pending_r) begin
          meas        = 1'b1;
          pending_nxt = (upd_r != '0);
        end else if (cnt_r > CNT_W'(upd_r)) begin
          cnt_nxt     = '0;
          pending_nxt = 1'b1;
        end else begin
          cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pending_r <= 1'b1;
      cnt_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Peak tracker lanes, one per channel.
  sample_t   smp [CHANNELS];
  peak_idx_t idx_nxt [CHANNELS];

  assign smp[0] = in_sample_ch0;
  assign smp[1] = in_sample_ch1;
  assign smp[2] = in_sample_ch2;
  assign smp[3] = in_sample_ch3;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_peak
    mtpo_peak_lane u_peak (
      .clk     (clk),
      .rst_n   (rst_n),
      .acc     (acc),
      .sample  (smp[c]),
      .pos     (pos_r),
      .period  (p_c),
      .idx_nxt (idx_nxt[c])
    );
  end

  // Capture stage: the peak positions as they stand after the frame's last
  // sample, together with the period and the measurement decision.
  pipe_ctl_t         cap_ctl_r;
  logic [IDX1_W-1:0] cap_ref_r;
  logic [P_W-1:0]    cap_per_r;
  peak_idx_t         cap_idx_r [1:CHANNELS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_ctl_r <= '0;
    end else if (en) begin
      cap_ctl_r <= '{valid: acc && frame_end, meas: meas, act: act_c};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cap_ref_r <= idx_nxt[0].first_idx;
      cap_per_r <= p_c;
      for (int c = 1; c < CHANNELS; c++) begin
        cap_idx_r[c] <= idx_nxt[c];
      end
    end
  end

  // Remainder lanes for the channels measured against channel 0.
  offset_t lane_off [1:CHANNELS-1];

  for (genvar c = 1; c < CHANNELS; c++) begin : g_rem
    mtpo_rem_lane u_rem (
      .clk     (clk),
      .en      (en),
      .ref_idx (cap_ref_r),
      .idx     (cap_idx_r[c]),
      .period  (cap_per_r),
      .offset  (lane_off[c])
    );
  end

  // Control shadow of the remainder pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= cap_ctl_r;
      for (int k = 0; k < DIV_STAGES; k++) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end
  end

  // Merge: a measuring frame replaces the stored offsets (inactive channels are
  // cleared), every frame reports the stored offsets of its active channels.
  offset_t   offset_r  [1:CHANNELS-1];
  offset_t   off_nxt   [1:CHANNELS-1];
  offset_t   res_nxt   [1:CHANNELS-1];
  offset_t   res_r     [1:CHANNELS-1];
  pipe_ctl_t last;

  assign last = ctl_r[DIV_STAGES];

  always_comb begin
    for (int c = 1; c < CHANNELS; c++) begin
      if (last.meas) begin
        off_nxt[c] = (ACT_W'(c) < last.act) ? lane_off[c] : '0;
      end else begin
        off_nxt[c] = offset_r[c];
      end
      res_nxt[c] = (ACT_W'(c) < last.act) ? off_nxt[c] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int c = 1; c < CHANNELS; c++) begin
        offset_r[c] <= '0;
      end
    end else if (en && last.valid) begin
      out_valid_r <= 1'b1;
      for (int c = 1; c < CHANNELS; c++) begin
        offset_r[c] <= off_nxt[c];
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last.valid) begin
      for (int c = 1; c < CHANNELS; c++) begin
        res_r[c] <= res_nxt[c];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_offset_ch1 = res_r[1];
  assign out_offset_ch2 = res_r[2];
  assign out_offset_ch3 = res_r[3];

endmodule

>>> src/mtpo_checker.sv
// Port-level checks of the multichannel tone phase offset unit and their binding.
module mtpo_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mtpo_pkg::offset_t out_offset_ch1,
  input mtpo_pkg::offset_t out_offset_ch2,
  input mtpo_pkg::offset_t out_offset_ch3
);
  import mtpo_pkg::*;

  // A blocked result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A blocked result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_offset_ch1) && $stable(out_offset_ch2) &&
                               $stable(out_offset_ch3))
    else $error("result payload changed while stalled");

  // The input is only held off by a result that waits downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A remainder by the period never reaches the most negative code.
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_offset_ch1[OFF_W-1] && out_offset_ch1[OFF_W-2:0] == '0) &&
                  !(out_offset_ch2[OFF_W-1] && out_offset_ch2[OFF_W-2:0] == '0) &&
                  !(out_offset_ch3[OFF_W-1] && out_offset_ch3[OFF_W-2:0] == '0))
    else $error("offset out of range");

endmodule

bind multichannel_tone_phase_offset_unit mtpo_checker u_mtpo_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_offset_ch1 (out_offset_ch1),
  .out_offset_ch2 (out_offset_ch2),
  .out_offset_ch3 (out_offset_ch3)
);

>>> sim/tb_top.sv
// Self-checking testbench for the multichannel tone phase offset unit.
module tb_top;
  import mtpo_pkg::*;

  // Cycles to let pass after the last result before touching the registers or
  // ending the run.
  localparam int DRAIN_CYCLES = 40;

  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_set_t;
  typedef logic [CHANNELS-1:1][OFF_W-1:0]       offset_set_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {STYLE_TONE, STYLE_NOISE, STYLE_CORNER} frame_style_t;

  // Tracks the unit's peak search, refresh counter and stored offsets, and holds
  // the offset transactions that the unit owes.
  class phase_offset_tracker;
    logic [SPP_W-1:0]  spp;
    logic [FLEN_W-1:0] flen;
    logic [UPD_W-1:0]  upd;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  frame_pos;
    sample_t           first_val [CHANNELS];
    logic [IDX1_W-1:0] first_idx [CHANNELS];
    sample_t           second_val [CHANNELS];
    logic [POS_W-1:0]  second_idx [CHANNELS];
    bit                measure_armed;
    logic [CNT_W-1:0]  skip_count;
    offset_set_t       held_offsets;
    offset_set_t       expected_offsets [$];
    int                frames_noted;
    int                mismatches;

    function new();
      int c;
      spp = 16;
      flen = 64;
      upd = 0;
      act = 4;
      frame_pos = '0;
      for (c = 0; c < CHANNELS; c++) begin
        first_val[c] = '0;
        first_idx[c] = '0;
        second_val[c] = '0;
        second_idx[c] = '0;
      end
      measure_armed = 1'b1;
      skip_count = '0;
      held_offsets = '0;
      frames_noted = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        REG_SPP:  spp = val[SPP_W-1:0];
        REG_FLEN: flen = val[FLEN_W-1:0];
        REG_UPD:  upd = val[UPD_W-1:0];
        REG_ACT:  act = val[ACT_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      int len;
      len = flen;
      if (len < 4) len = 4;
      if (len > MAX_FRAME) len = MAX_FRAME;
      return len;
    endfunction

    // Both tone periods must fit in the frame.
    function int eff_period();
      int per;
      per = spp;
      if (per > MAX_PERIOD) per = MAX_PERIOD;
      if (per > eff_len() / 2) per = eff_len() / 2;
      if (per < 2) per = 2;
      return per;
    endfunction

    function int eff_active();
      int n;
      n = act;
      if (n < 2) n = 2;
      if (n > CHANNELS) n = CHANNELS;
      return n;
    endfunction

    function int pending();
      return expected_offsets.size();
    endfunction

    function void take_samples(sample_set_t smp);
      int len, per, nact, pos, c, anchor, d_first, d_second, d_near;
      sample_t s;
      offset_set_t result;
      len = eff_len();
      per = eff_period();
      nact = eff_active();
      pos = frame_pos;
      // Strict compare: on ties the earliest sample of each window stays.
      for (c = 0; c < CHANNELS; c++) begin
        s = smp[c];
        if (pos == 0 || (pos < per && s > first_val[c])) begin
          first_val[c] = s;
          first_idx[c] = IDX1_W'(pos);
        end
        if (pos == per || (pos > per && pos < 2 * per && s > second_val[c])) begin
          second_val[c] = s;
          second_idx[c] = POS_W'(pos);
        end
      end
      // A position at or past the last one ends the frame, which covers a frame
      // that was shortened while it was under way.
      if (pos + 1 < len) begin
        frame_pos = POS_W'(pos + 1);
        return;
      end
      frame_pos = '0;
      frames_noted++;
      if (measure_armed) begin
        anchor = int'(first_idx[0]);
        for (c = 1; c < CHANNELS; c++) begin
          if (c >= nact) begin
            held_offsets[c] = '0;
          end else begin
            d_first = anchor - int'(first_idx[c]);
            d_second = anchor - int'(second_idx[c]);
            // The first-period peak wins only when strictly nearer.
            d_near = (((d_first < 0) ? -d_first : d_first) <
                      ((d_second < 0) ? -d_second : d_second)) ? d_first : d_second;
            held_offsets[c] = OFF_W'(d_near % per);
          end
        end
        measure_armed = (upd != 0);
      end else if (skip_count > upd) begin
        skip_count = '0;
        measure_armed = 1'b1;
      end else begin
        skip_count++;
      end
      for (c = 1; c < CHANNELS; c++)
        result[c] = (c < nact) ? held_offsets[c] : '0;
      expected_offsets = {expected_offsets, result};
    endfunction

    function void compare_offsets(offset_set_t got);
      offset_set_t want;
      int c;
      if (expected_offsets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("offset transaction with nothing owed: ch1 %0d ch2 %0d ch3 %0d",
                   $signed(got[1]), $signed(got[2]), $signed(got[3]));
        return;
      end
      want = expected_offsets.pop_front();
      for (c = 1; c < CHANNELS; c++) begin
        if (got[c] !== want[c]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("offset mismatch on channel %0d: expected %0d, got %0d",
                     c, $signed(want[c]), $signed(got[c]));
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  sample_t             in_sample_ch0;
  sample_t             in_sample_ch1;
  sample_t             in_sample_ch2;
  sample_t             in_sample_ch3;
  logic                out_valid;
  logic                out_stall;
  offset_t             out_offset_ch1;
  offset_t             out_offset_ch2;
  offset_t             out_offset_ch3;

  phase_offset_tracker trk;

  // Idling knobs, in percent of cycles, and the long receiver hold-off.
  int send_gap_pct;
  int recv_stall_pct;
  int recv_hold_cycles;

  // Shape of the frame being generated; chosen again at each frame start.
  frame_style_t style;
  int           tone_shift [CHANNELS];
  int           tone_amp [CHANNELS];
  int           tone_slope;
  int           tone_noise;

  multichannel_tone_phase_offset_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_ch0  (in_sample_ch0),
    .in_sample_ch1  (in_sample_ch1),
    .in_sample_ch2  (in_sample_ch2),
    .in_sample_ch3  (in_sample_ch3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_offset_ch1 (out_offset_ch1),
    .out_offset_ch2 (out_offset_ch2),
    .out_offset_ch3 (out_offset_ch3)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides its stall at each falling edge. A pending hold-off
  // wins over the random stall and is counted down here, one cycle at a time.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        out_stall <= 1'b1;
        recv_hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every accepted offset transaction is checked against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      trk.compare_offsets({out_offset_ch3, out_offset_ch2, out_offset_ch1});
  end

  function automatic void set_idling(input idle_mode_t m);
    case (m)
      IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_gap_pct = 52; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 52; end
      default:       begin send_gap_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endfunction

  function automatic sample_t clip_sample(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  function automatic sample_set_t pack_samples(input int s0, input int s1,
                                               input int s2, input int s3);
    return {clip_sample(s3), clip_sample(s2), clip_sample(s1), clip_sample(s0)};
  endfunction

  // Most frames carry a peaked tone per channel with its own phase, so the
  // peaks land where the offsets mean something; the rest are full-range noise
  // or a handful of corner values that force ties.
  function automatic sample_set_t next_item();
    sample_set_t smp;
    int pos, per, c, k, ring_gap, roll;
    pos = trk.frame_pos;
    per = trk.eff_period();
    if (pos == 0) begin
      roll = $urandom_range(99);
      if (roll < 70) style = STYLE_TONE;
      else if (roll < 90) style = STYLE_NOISE;
      else style = STYLE_CORNER;
      tone_slope = $urandom_range(1, 3000);
      tone_noise = $urandom_range(0, 40);
      for (c = 0; c < CHANNELS; c++) begin
        tone_shift[c] = $urandom_range(0, per - 1);
        tone_amp[c] = int'($urandom_range(0, 49151)) - 16384;
      end
    end
    for (c = 0; c < CHANNELS; c++) begin
      case (style)
        STYLE_TONE: begin
          k = (pos + tone_shift[c]) % per;
          ring_gap = (k < per - k) ? k : per - k;
          smp[c] = clip_sample(tone_amp[c] - ring_gap * tone_slope
                               + int'($urandom_range(0, 2 * tone_noise)) - tone_noise);
        end
        STYLE_NOISE: smp[c] = SAMPLE_BITS'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(3))
            0: smp[c] = 16'sh8000;
            1: smp[c] = 16'sh7fff;
            2: smp[c] = '0;
            default: smp[c] = '1;
          endcase
        end
      endcase
    end
    return smp;
  endfunction

  // One sample transaction; the payload holds until the unit takes it.
  task automatic send_item(input sample_set_t smp);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample_ch0 <= smp[0];
    in_sample_ch1 <= smp[1];
    in_sample_ch2 <= smp[2];
    in_sample_ch3 <= smp[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.take_samples(smp);
  endtask

  task automatic stop_offering();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sends generated samples until the given number of frames has closed.
  task automatic run_frames(input int nframes);
    int target;
    target = trk.frames_noted + nframes;
    while (trk.frames_noted < target) send_item(next_item());
    stop_offering();
  endtask

  // Waits until every owed result has come and the pipeline has emptied.
  task automatic settle();
    while (trk.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    trk.write_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input int spp, input int flen, input int upd, input int nact);
    settle();
    apb_write(REG_SPP, spp);
    apb_write(REG_FLEN, flen);
    apb_write(REG_UPD, upd);
    apb_write(REG_ACT, nact);
  endtask

  initial begin
    int ph, spp_v, flen_v, upd_v, act_v, roll;
    trk = new();
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_sample_ch0 = '0;
    in_sample_ch1 = '0;
    in_sample_ch2 = '0;
    in_sample_ch3 = '0;
    recv_hold_cycles = 0;
    style = STYLE_NOISE;
    set_idling(IDLE_NONE);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults straight after reset: 64-sample frames, period 16.
    set_idling(IDLE_BOTH);
    run_frames(1);

    // Directed frames with the shortest legal frame and period.
    set_idling(IDLE_NONE);
    set_config(2, 4, 1, 4);
    // Equal samples everywhere: the earliest sample of each window must win.
    repeat (4) send_item(pack_samples(32767, 32767, 32767, 32767));
    // Full-scale swings: a nearer first peak, a distance tie that goes to the
    // second peak, and a channel that lines up with the reference.
    send_item(pack_samples(-32768, 32767, -32768, -1));
    send_item(pack_samples(32767, -32768, -32768, 0));
    send_item(pack_samples(-32768, -32768, 32767, -1));
    send_item(pack_samples(32767, 32767, -32768, 0));
    repeat (4) send_item(pack_samples(-32768, -32768, -32768, -32768));
    stop_offering();

    // A frame cut short while under way: the next sample must close it.
    set_config(2, 8, 1, 4);
    send_item(pack_samples(5, 900, -7, 3));
    send_item(pack_samples(100, 2, 30000, -3));
    send_item(pack_samples(-50, 7, 1, 20000));
    send_item(pack_samples(9, 32767, 4, -32768));
    send_item(pack_samples(0, 1, 2, 3));
    stop_offering();
    settle();
    apb_write(REG_FLEN, 4);
    send_item(pack_samples(1, -1, 1, -1));
    stop_offering();

    // Register extremes. The first frame starts with every register but the update
    // interval at its largest value, which clamps the frame, the period and the
    // channel count, and is then cut short so that it closes on the next sample.
    set_idling(IDLE_BOTH);
    set_config(8191, 16383, 0, 7);
    repeat (12) send_item(next_item());
    stop_offering();
    settle();
    apb_write(REG_FLEN, 4);
    send_item(next_item());
    stop_offering();
    set_idling(IDLE_SENDER);
    set_config(4096, 20, 65535, 1);
    run_frames(2);
    set_idling(IDLE_RECEIVER);
    set_config(0, 0, 0, 0);
    run_frames(4);
    set_config(1, 3, 2, 3);
    run_frames(4);
    set_idling(IDLE_NONE);
    set_config(2, 5, 0, 2);
    run_frames(6);
    set_config(3, 6, 2, 4);
    run_frames(6);

    // The receiver holds off for a long stretch while samples keep coming, so a
    // second result reaches the pipeline's last stage and the input stall has to rise.
    set_config(2, 4, 1, 4);
    recv_hold_cycles = 400;
    run_frames(24);

    // Random settings, mostly short frames so that results come often.
    for (ph = 0; ph < 6; ph++) begin
      roll = $urandom_range(99);
      if (roll < 80) spp_v = $urandom_range(2, 8);
      else if (roll < 90) spp_v = $urandom_range(0, 1);
      else spp_v = $urandom_range(4096, 8191);
      roll = $urandom_range(99);
      if (roll < 80) flen_v = $urandom_range(4, 12);
      else if (roll < 90) flen_v = $urandom_range(0, 3);
      else flen_v = $urandom_range(21, 40);
      roll = $urandom_range(99);
      if (roll < 50) upd_v = 0;
      else if (roll < 80) upd_v = $urandom_range(1, 3);
      else upd_v = $urandom_range(0, 65535);
      act_v = $urandom_range(0, 7);
      set_config(spp_v, flen_v, upd_v, act_v);
      set_idling(idle_mode_t'(ph % 4));
      run_frames($urandom_range(1, 3));
    end

    settle();
    if (trk.mismatches == 0 && trk.pending() == 0) begin
      $display("multichannel_tone_phase_offset_unit regression: pass");
    end else begin
      $display("multichannel_tone_phase_offset_unit regression: fail");
    end
    $finish;
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("multichannel_tone_phase_offset_unit regression: fail");
    $finish;
  end

endmodule
